// ===== hdl/bsa_pkg.sv =====
package bsa_pkg;

	localparam int WORD_BITS = 64;

	localparam logic [1:0] ST_OK       = 2'd0;
	localparam logic [1:0] ST_FULL     = 2'd1;
	localparam logic [1:0] ST_BAD_FREE = 2'd2;

	localparam logic REQ_ALLOC = 1'b0;
	localparam logic REQ_FREE  = 1'b1;

	localparam logic [8:0] SPB_RESET = 9'd256;

	typedef struct packed {
		logic       done;
		logic [5:0] idx;
	} find_rsp_t;

endpackage

// ===== hdl/bitmap_slot_allocator.sv =====
// One request per start pulse; busy stays high until the result strobe. A free goes from
// a check state to a write state; one refused on its buffer, slot or counts ends before
// the bitmap is read. An allocate picks the first open buffer with space, scans its
// bitmap words in order for a nonzero one and takes the slot at the buffer's used count
// when that slot is free. A buffer flagged with space whose bitmap is empty is scanned
// to its last word, loses the flag, and the pick is made again. An allocate that opens a
// new buffer first writes every word of its bitmap. Falling back to the lowest-set-bit
// search goes through one byte of the word per cycle. An allocate refused because every
// buffer is full ends at the pick, after any empty-buffer scans. The bitmap lives in a
// single-port memory, one word per access. Results appear for one cycle with done high
// and cannot be held off; a new start is taken in the same cycle that done is high.
// live_total always shows the current count of allocated slots. The configuration port
// is always ready.
module bitmap_slot_allocator #(
	parameter int MAX_BUFFERS      = 16,
	parameter int WORDS_PER_BUFFER = 4
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        start,
	output logic        busy,
	input  logic        req_type,
	input  logic [3:0]  free_buffer,
	input  logic [7:0]  free_slot,
	input  logic        cfg_valid,
	output logic        cfg_ready,
	input  logic [8:0]  cfg_data,
	output logic        done,
	output logic [1:0]  status,
	output logic [3:0]  got_buffer,
	output logic [7:0]  got_slot,
	output logic [12:0] live_total
);

	localparam int DEPTH = MAX_BUFFERS * WORDS_PER_BUFFER;
	localparam int BW    = (MAX_BUFFERS > 1) ? $clog2(MAX_BUFFERS) : 1;
	localparam int WW    = (WORDS_PER_BUFFER > 1) ? $clog2(WORDS_PER_BUFFER) : 1;
	localparam int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int OW    = $clog2(MAX_BUFFERS + 1);
	localparam int BITS  = WORDS_PER_BUFFER * bsa_pkg::WORD_BITS;
	localparam int CAP   = (BITS > 256) ? 256 : BITS;

	localparam logic [3:0] S_IDLE     = 4'd0;
	localparam logic [3:0] S_PICK     = 4'd1;
	localparam logic [3:0] S_SCAN_RD  = 4'd2;
	localparam logic [3:0] S_SCAN_CHK = 4'd3;
	localparam logic [3:0] S_OPEN_WR  = 4'd4;
	localparam logic [3:0] S_FC_RD    = 4'd5;
	localparam logic [3:0] S_FC_CHK   = 4'd6;
	localparam logic [3:0] S_FIND     = 4'd7;
	localparam logic [3:0] S_COMMIT   = 4'd8;
	localparam logic [3:0] S_FREE_CHK = 4'd9;
	localparam logic [3:0] S_FREE_WR  = 4'd10;

	function automatic logic [AW-1:0] waddr(logic [BW-1:0] b, logic [WW-1:0] w);
		return AW'(int'(b) * WORDS_PER_BUFFER + int'(w));
	endfunction

	function automatic logic [WW-1:0] word_of(logic [8:0] s);
		logic [8:0] t;
		t = s >> 6;
		return t[WW-1:0];
	endfunction

	function automatic logic [bsa_pkg::WORD_BITS-1:0] fill_word(logic [8:0] spb,
		logic [WW-1:0] w);
		int n;
		n = int'(spb) - int'(w) * bsa_pkg::WORD_BITS;
		if (n >= bsa_pkg::WORD_BITS) begin
			return '1;
		end else if (n <= 0) begin
			return '0;
		end
		return {bsa_pkg::WORD_BITS{1'b1}} >> 7'(bsa_pkg::WORD_BITS - n);
	endfunction

	// control state
	logic [3:0]             state_q;
	logic                   done_q;
	logic [8:0]             slots_q;
	logic [MAX_BUFFERS-1:0] has_space_q;
	logic [8:0]             used_q [MAX_BUFFERS];
	logic [OW-1:0]          open_q;
	logic [12:0]            total_q;

	// request payload
	logic                          req_q;
	logic [3:0]                    fb_q;
	logic [7:0]                    fs_q;
	logic [8:0]                    spb_q;
	logic [BW-1:0]                 buf_q;
	logic [WW-1:0]                 widx_q;
	logic [WW-1:0]                 fw_q;
	logic [bsa_pkg::WORD_BITS-1:0] fword_q;
	logic [7:0]                    gs_q;
	logic [1:0]                    status_q;
	logic [3:0]                    got_buffer_q;
	logic [7:0]                    got_slot_q;

	logic [8:0]                    eff_spb;
	logic [MAX_BUFFERS-1:0]        open_mask;
	logic [MAX_BUFFERS-1:0]        avail;
	logic [BW-1:0]                 pick_idx;
	logic [8:0]                    cur_used;
	logic [8:0]                    used_inc;
	logic                          fc_in_map;
	logic [WW-1:0]                 fc_widx;
	logic                          fc_bit;
	logic [WW-1:0]                 fs_widx;
	logic                          fs_bit;
	logic                          free_ok;
	logic                          widx_last;
	logic                          req_end;
	logic                          mem_we;
	logic [AW-1:0]                 mem_addr;
	logic [bsa_pkg::WORD_BITS-1:0] mem_wdata;
	logic [bsa_pkg::WORD_BITS-1:0] mem_rdata;
	logic                          find_start;
	bsa_pkg::find_rsp_t            find_rsp;

	always_comb begin
		if (slots_q == 9'd0) begin
			eff_spb = 9'd1;
		end else if (int'(slots_q) > CAP) begin
			eff_spb = 9'(CAP);
		end else begin
			eff_spb = slots_q;
		end

		for (int i = 0; i < MAX_BUFFERS; i++) begin
			open_mask[i] = (i < int'(open_q));
		end
		avail = has_space_q & open_mask;
		pick_idx = '0;
		for (int i = MAX_BUFFERS - 1; i >= 0; i--) begin
			if (avail[i]) begin
				pick_idx = BW'(i);
			end
		end

		cur_used  = used_q[buf_q];
		used_inc  = cur_used + 9'd1;
		fc_in_map = (int'(cur_used) < BITS);
		fc_widx   = word_of(cur_used);
		fc_bit    = mem_rdata[cur_used[5:0]];
		fs_widx   = word_of({1'b0, fs_q});
		fs_bit    = mem_rdata[fs_q[5:0]];
		free_ok   = (int'(fb_q) < MAX_BUFFERS) && (int'(fb_q) < int'(open_q)) &&
			({1'b0, fs_q} < spb_q) && (cur_used != 9'd0) && (total_q != 13'd0);
		widx_last = (int'(widx_q) == WORDS_PER_BUFFER - 1);

		// last cycle of a request: the result beat follows
		req_end = ((state_q == S_PICK) && (avail == '0) && (int'(open_q) >= MAX_BUFFERS)) ||
			(state_q == S_COMMIT) || ((state_q == S_FREE_CHK) && !free_ok) ||
			(state_q == S_FREE_WR);

		mem_we    = 1'b0;
		mem_addr  = waddr(buf_q, widx_q);
		mem_wdata = fill_word(spb_q, widx_q);
		case (state_q)
			S_OPEN_WR: begin
				mem_we = 1'b1;
			end
			S_FC_RD: begin
				mem_addr = waddr(buf_q, fc_widx);
			end
			S_FC_CHK: begin
				mem_addr  = waddr(buf_q, fc_widx);
				mem_we    = fc_bit;
				mem_wdata = mem_rdata & ~({{(bsa_pkg::WORD_BITS-1){1'b0}}, 1'b1} <<
					cur_used[5:0]);
			end
			S_FIND: begin
				mem_addr  = waddr(buf_q, fw_q);
				mem_we    = find_rsp.done;
				mem_wdata = fword_q & ~({{(bsa_pkg::WORD_BITS-1){1'b0}}, 1'b1} <<
					find_rsp.idx);
			end
			S_FREE_CHK: begin
				mem_addr = waddr(buf_q, fs_widx);
			end
			S_FREE_WR: begin
				mem_addr  = waddr(buf_q, fs_widx);
				mem_we    = !fs_bit;
				mem_wdata = mem_rdata | ({{(bsa_pkg::WORD_BITS-1){1'b0}}, 1'b1} << fs_q[5:0]);
			end
			default: begin
			end
		endcase

		find_start = ((state_q == S_FC_RD) && !fc_in_map) ||
			((state_q == S_FC_CHK) && !fc_bit);
	end

	bsa_bitmap_ram #(
		.DEPTH(DEPTH),
		.AW   (AW)
	) u_ram (
		.clk  (clk),
		.we   (mem_we),
		.addr (mem_addr),
		.wdata(mem_wdata),
		.rdata(mem_rdata)
	);

	bsa_lsb_find u_find (
		.clk   (clk),
		.arst_n(arst_n),
		.start (find_start),
		.word  (fword_q),
		.rsp   (find_rsp)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_IDLE;
			done_q      <= 1'b0;
			slots_q     <= bsa_pkg::SPB_RESET;
			has_space_q <= '0;
			open_q      <= '0;
			total_q     <= '0;
			for (int i = 0; i < MAX_BUFFERS; i++) begin
				used_q[i] <= '0;
			end
		end else begin
			done_q <= req_end;
			if (cfg_valid) begin
				slots_q <= cfg_data;
			end
			case (state_q)
				S_IDLE: begin
					if (start) begin
						state_q <= (req_type == bsa_pkg::REQ_FREE) ? S_FREE_CHK : S_PICK;
					end
				end
				S_PICK: begin
					if (avail != '0) begin
						state_q <= S_SCAN_RD;
					end else if (int'(open_q) < MAX_BUFFERS) begin
						state_q <= S_OPEN_WR;
					end else begin
						state_q <= S_IDLE;
					end
				end
				S_SCAN_RD: begin
					state_q <= S_SCAN_CHK;
				end
				S_SCAN_CHK: begin
					if (mem_rdata != '0) begin
						state_q <= S_FC_RD;
					end else if (widx_last) begin
						// flagged but empty: drop the flag and pick again
						has_space_q[buf_q] <= 1'b0;
						state_q            <= S_PICK;
					end else begin
						state_q <= S_SCAN_RD;
					end
				end
				S_OPEN_WR: begin
					if (widx_last) begin
						used_q[buf_q]      <= '0;
						has_space_q[buf_q] <= 1'b1;
						open_q             <= open_q + 1'b1;
						state_q            <= S_FC_RD;
					end
				end
				S_FC_RD: begin
					state_q <= fc_in_map ? S_FC_CHK : S_FIND;
				end
				S_FC_CHK: begin
					state_q <= fc_bit ? S_COMMIT : S_FIND;
				end
				S_FIND: begin
					if (find_rsp.done) begin
						state_q <= S_COMMIT;
					end
				end
				S_COMMIT: begin
					used_q[buf_q] <= used_inc;
					total_q       <= total_q + 13'd1;
					if (used_inc >= spb_q) begin
						has_space_q[buf_q] <= 1'b0;
					end
					state_q <= S_IDLE;
				end
				S_FREE_CHK: begin
					if (free_ok) begin
						state_q <= S_FREE_WR;
					end else begin
						state_q <= S_IDLE;
					end
				end
				S_FREE_WR: begin
					if (!fs_bit) begin
						used_q[buf_q]      <= cur_used - 9'd1;
						total_q            <= total_q - 13'd1;
						has_space_q[buf_q] <= 1'b1;
					end
					state_q <= S_IDLE;
				end
				default: begin
					state_q <= S_IDLE;
				end
			endcase
		end
	end

	always_ff @(posedge clk) begin
		case (state_q)
			S_IDLE: begin
				if (start) begin
					req_q <= req_type;
					fb_q  <= free_buffer;
					fs_q  <= free_slot;
					spb_q <= eff_spb;
					buf_q <= BW'(free_buffer);
				end
			end
			S_PICK: begin
				widx_q <= '0;
				if (avail != '0) begin
					buf_q <= pick_idx;
				end else if (int'(open_q) < MAX_BUFFERS) begin
					buf_q <= BW'(open_q);
				end else begin
					status_q     <= bsa_pkg::ST_FULL;
					got_buffer_q <= '0;
					got_slot_q   <= '0;
				end
			end
			S_SCAN_CHK: begin
				if (mem_rdata != '0) begin
					fw_q    <= widx_q;
					fword_q <= mem_rdata;
				end else if (!widx_last) begin
					widx_q <= widx_q + 1'b1;
				end
			end
			S_OPEN_WR: begin
				if (!widx_last) begin
					widx_q <= widx_q + 1'b1;
				end
			end
			S_FC_CHK: begin
				if (fc_bit) begin
					gs_q <= cur_used[7:0];
				end
			end
			S_FIND: begin
				if (find_rsp.done) begin
					gs_q <= 8'(int'(fw_q) * bsa_pkg::WORD_BITS + int'(find_rsp.idx));
				end
			end
			S_COMMIT: begin
				status_q     <= bsa_pkg::ST_OK;
				got_buffer_q <= 4'(buf_q);
				got_slot_q   <= gs_q;
			end
			S_FREE_CHK: begin
				status_q     <= bsa_pkg::ST_BAD_FREE;
				got_buffer_q <= '0;
				got_slot_q   <= '0;
			end
			S_FREE_WR: begin
				status_q <= fs_bit ? bsa_pkg::ST_BAD_FREE : bsa_pkg::ST_OK;
			end
			default: begin
			end
		endcase
	end

	assign busy       = (state_q != S_IDLE);
	assign cfg_ready  = 1'b1;
	assign done       = done_q;
	assign status     = status_q;
	assign got_buffer = got_buffer_q;
	assign got_slot   = got_slot_q;
	assign live_total = total_q;

	a_done_idle: assert property (@(posedge clk) disable iff (!arst_n)
		done |-> !busy)
		else $error("result strobe while a request is still in flight");

	a_fail_zero: assert property (@(posedge clk) disable iff (!arst_n)
		done && (status != bsa_pkg::ST_OK) |-> (got_buffer == 4'd0) && (got_slot == 8'd0))
		else $error("failed request reports a slot");

	a_free_zero: assert property (@(posedge clk) disable iff (!arst_n)
		done && (req_q == bsa_pkg::REQ_FREE) |-> (got_buffer == 4'd0) && (got_slot == 8'd0))
		else $error("free request reports a slot");

	a_open_bound: assert property (@(posedge clk) disable iff (!arst_n)
		int'(open_q) <= MAX_BUFFERS)
		else $error("open buffer count beyond limit");

	a_total_hold: assert property (@(posedge clk) disable iff (!arst_n)
		!busy |=> live_total == $past(live_total))
		else $error("live total moved without a request at work");

	a_find_state: assert property (@(posedge clk) disable iff (!arst_n)
		find_rsp.done |-> (state_q == S_FIND))
		else $error("bit search finished outside its state");

endmodule

// ===== hdl/bsa_bitmap_ram.sv =====
module bsa_bitmap_ram #(
	parameter int DEPTH = 64,
	parameter int AW    = 6
) (
	input  logic                          clk,
	input  logic                          we,
	input  logic [AW-1:0]                 addr,
	input  logic [bsa_pkg::WORD_BITS-1:0] wdata,
	output logic [bsa_pkg::WORD_BITS-1:0] rdata
);

	logic [bsa_pkg::WORD_BITS-1:0] mem [DEPTH];
	logic [bsa_pkg::WORD_BITS-1:0] rdata_q;

	always_ff @(posedge clk) begin
		if (we) begin
			mem[addr] <= wdata;
		end
		rdata_q <= mem[addr];
	end

	assign rdata = rdata_q;

endmodule

// ===== hdl/bsa_lsb_find.sv =====
module bsa_lsb_find (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          start,
	input  logic [bsa_pkg::WORD_BITS-1:0] word,
	output bsa_pkg::find_rsp_t            rsp
);

	logic [bsa_pkg::WORD_BITS-1:0] word_q;
	logic [2:0]                    byte_q;
	logic                          run_q;
	logic [7:0]                    cur_byte;
	logic [2:0]                    enc;
	logic                          hit;

	always_comb begin
		cur_byte = word_q[{byte_q, 3'b000} +: 8];
		enc = 3'd0;
		// lowest set bit wins: scan from the top down
		for (int i = 7; i >= 0; i--) begin
			if (cur_byte[i]) begin
				enc = 3'(i);
			end
		end
		hit = (cur_byte != 8'd0) || (byte_q == 3'd7);
		rsp.done = run_q && hit;
		rsp.idx  = {byte_q, enc};
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			run_q  <= 1'b0;
			byte_q <= 3'd0;
		end else if (start) begin
			run_q  <= 1'b1;
			byte_q <= 3'd0;
		end else if (run_q) begin
			if (hit) begin
				run_q <= 1'b0;
			end else begin
				byte_q <= byte_q + 3'd1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			word_q <= word;
		end
	end

endmodule

// ===== dv/tb.sv =====
module tb;

	localparam int NBUF        = 16;
	localparam int WPB         = 4;
	localparam int CYCLE_LIMIT = 500000;
	localparam int DRAIN       = 40;

	typedef struct packed {
		logic [1:0]  status;
		logic [3:0]  got_buffer;
		logic [7:0]  got_slot;
		logic [12:0] live_total;
	} slot_result_t;

	typedef enum logic [1:0] {PLAN_ALLOC, PLAN_FREE_HELD, PLAN_FREE_ANY} plan_kind_t;

	typedef struct {
		plan_kind_t kind;
		logic [3:0] fb;
		logic [7:0] fs;
	} plan_t;

	logic        clk = 1'b0;
	logic        arst_n = 1'b0;
	logic        start = 1'b0;
	logic        busy;
	logic        req_type = bsa_pkg::REQ_ALLOC;
	logic [3:0]  free_buffer = 4'd0;
	logic [7:0]  free_slot = 8'd0;
	logic        cfg_valid = 1'b0;
	logic        cfg_ready;
	logic [8:0]  cfg_data = 9'd0;
	logic        done;
	logic [1:0]  status;
	logic [3:0]  got_buffer;
	logic [7:0]  got_slot;
	logic [12:0] live_total;

	// shadow of the allocator
	logic [63:0] map_words [NBUF*WPB];
	logic [8:0]  buf_used [NBUF];
	logic        buf_room [NBUF];
	int          bufs_opened = 0;
	logic [12:0] slots_live = 13'd0;
	logic [8:0]  slots_cfg = bsa_pkg::SPB_RESET;
	logic [11:0] held [$];

	plan_t        req_plan [$];
	slot_result_t owed_results [$];

	int faults = 0;
	int taken_cnt = 0;
	int idle_left = 0;
	int idle_pct = 20;
	bit quiet = 1'b0;
	int cyc = 0;

	bitmap_slot_allocator i_dut (
		.clk        (clk),
		.arst_n     (arst_n),
		.start      (start),
		.busy       (busy),
		.req_type   (req_type),
		.free_buffer(free_buffer),
		.free_slot  (free_slot),
		.cfg_valid  (cfg_valid),
		.cfg_ready  (cfg_ready),
		.cfg_data   (cfg_data),
		.done       (done),
		.status     (status),
		.got_buffer (got_buffer),
		.got_slot   (got_slot),
		.live_total (live_total)
	);

	initial begin
		forever #10 clk = ~clk;
	end

	task automatic apply_request(input logic rq, input logic [3:0] fb, input logic [7:0] fs,
			output slot_result_t r);
		int  lim, b, sel, w, i, s, k;
		bit  found, nz;
		lim = (slots_cfg == 0) ? 1 : ((slots_cfg > 256) ? 256 : int'(slots_cfg));
		r = '0;
		r.status = bsa_pkg::ST_OK;
		if (rq == bsa_pkg::REQ_ALLOC) begin
			found = 1'b0;
			sel = 0;
			for (b = 0; b < bufs_opened && !found; b++) begin
				if (buf_room[b]) begin
					nz = 1'b0;
					for (w = 0; w < WPB; w++)
						if (map_words[b*WPB + w] != 64'd0) nz = 1'b1;
					// flag set but bitmap empty: drop the flag and move on
					if (nz) begin
						found = 1'b1;
						sel = b;
					end else begin
						buf_room[b] = 1'b0;
					end
				end
			end
			if (!found && bufs_opened < NBUF) begin
				sel = bufs_opened;
				for (w = 0; w < WPB; w++)
					for (i = 0; i < 64; i++)
						map_words[sel*WPB + w][i] = (w*64 + i < lim);
				buf_used[sel] = 9'd0;
				buf_room[sel] = 1'b1;
				bufs_opened++;
				found = 1'b1;
			end
			if (!found) begin
				r.status = bsa_pkg::ST_FULL;
			end else begin
				s = buf_used[sel];
				if (!(s < WPB*64 && map_words[sel*WPB + s/64][s%64])) begin
					s = -1;
					for (w = 0; w < WPB; w++)
						for (i = 0; i < 64; i++)
							if (s < 0 && map_words[sel*WPB + w][i]) s = w*64 + i;
				end
				map_words[sel*WPB + s/64][s%64] = 1'b0;
				buf_used[sel] = buf_used[sel] + 9'd1;
				slots_live = slots_live + 13'd1;
				if (buf_used[sel] >= lim) buf_room[sel] = 1'b0;
				r.got_buffer = 4'(sel);
				r.got_slot = 8'(s);
				held.push_back({4'(sel), 8'(s)});
			end
		end else begin
			b = fb;
			s = fs;
			if (b >= bufs_opened || s >= lim || map_words[b*WPB + s/64][s%64] ||
					buf_used[b] == 9'd0 || slots_live == 13'd0) begin
				r.status = bsa_pkg::ST_BAD_FREE;
			end else begin
				map_words[b*WPB + s/64][s%64] = 1'b1;
				buf_used[b] = buf_used[b] - 9'd1;
				slots_live = slots_live - 13'd1;
				buf_room[b] = 1'b1;
				for (k = 0; k < held.size(); k++) begin
					if (held[k] == {fb, fs}) begin
						held.delete(k);
						break;
					end
				end
			end
		end
		r.live_total = slots_live;
	endtask

	// driver: accept beat, predict it, then present the next request
	always @(posedge clk) begin : drv
		slot_result_t r;
		plan_t p;
		int k;
		if (arst_n && !(start && busy)) begin
			if (start) begin
				apply_request(req_type, free_buffer, free_slot, r);
				owed_results.push_back(r);
				taken_cnt++;
				if (taken_cnt % 32 == 0) begin
					case ($urandom_range(0, 2))
						0: idle_pct = 0;
						1: idle_pct = 20;
						default: idle_pct = 60;
					endcase
				end
				if (!quiet && $urandom_range(0, 99) < idle_pct)
					idle_left = $urandom_range(1, 11);
			end
			if (quiet) idle_left = 0;
			if (idle_left > 0) begin
				idle_left--;
				start <= 1'b0;
			end else if (req_plan.size() != 0) begin
				p = req_plan.pop_front();
				start <= 1'b1;
				if (p.kind == PLAN_FREE_ANY) begin
					req_type <= bsa_pkg::REQ_FREE;
					free_buffer <= p.fb;
					free_slot <= p.fs;
				end else if (p.kind == PLAN_FREE_HELD && held.size() != 0) begin
					k = $urandom_range(0, held.size() - 1);
					req_type <= bsa_pkg::REQ_FREE;
					free_buffer <= held[k][11:8];
					free_slot <= held[k][7:0];
				end else begin
					// nothing held yet: turn it into an allocate
					req_type <= bsa_pkg::REQ_ALLOC;
					free_buffer <= 4'($urandom_range(0, 15));
					free_slot <= 8'($urandom_range(0, 255));
				end
			end else begin
				start <= 1'b0;
			end
		end
	end

	always @(posedge clk) begin : mon
		slot_result_t want;
		if (arst_n && cfg_valid && cfg_ready) slots_cfg = cfg_data;
		if (arst_n && done) begin
			if (owed_results.size() == 0) begin
				faults++;
				if (faults <= 10)
					$display("unexpected result: status %0d buffer %0d slot %0d live %0d",
						status, got_buffer, got_slot, live_total);
			end else begin
				want = owed_results.pop_front();
				if (want.status !== status || want.got_buffer !== got_buffer ||
						want.got_slot !== got_slot || want.live_total !== live_total) begin
					faults++;
					if (faults <= 10)
						$display({"mismatch: exp st %0d buf %0d slot %0d live %0d, ",
							"got st %0d buf %0d slot %0d live %0d"},
							want.status, want.got_buffer, want.got_slot, want.live_total,
							status, got_buffer, got_slot, live_total);
				end
			end
		end
	end

	initial begin
		while (cyc < CYCLE_LIMIT) begin
			@(posedge clk);
			cyc++;
		end
		$display("Regression FAIL");
		$finish;
	end

	task automatic push_plan(input plan_kind_t kind, input int fb = 0, input int fs = 0);
		plan_t p;
		p.kind = kind;
		p.fb = 4'(fb);
		p.fs = 8'(fs);
		req_plan.push_back(p);
	endtask

	task automatic plan_mix(input int n, input int alloc_pct, input int held_pct);
		int j, roll;
		for (j = 0; j < n; j++) begin
			roll = $urandom_range(0, 99);
			if (roll < alloc_pct)
				push_plan(PLAN_ALLOC);
			else if (roll < alloc_pct + held_pct)
				push_plan(PLAN_FREE_HELD);
			else if ($urandom_range(0, 1))
				push_plan(PLAN_FREE_ANY, $urandom_range(0, 15), $urandom_range(0, 255));
			else
				push_plan(PLAN_FREE_ANY, $urandom_range(0, 3), $urandom_range(0, 15));
		end
	endtask

	// wait until the block is idle with nothing in flight
	task automatic settle();
		do @(negedge clk);
		while (req_plan.size() != 0 || start || busy || owed_results.size() != 0);
	endtask

	task automatic write_slots(input logic [8:0] v);
		settle();
		@(posedge clk);
		cfg_valid <= 1'b1;
		cfg_data <= v;
		do @(posedge clk);
		while (!cfg_ready);
		cfg_valid <= 1'b0;
		@(negedge clk);
	endtask

	initial begin
		int k;
		for (k = 0; k < NBUF*WPB; k++) map_words[k] = 64'd0;
		for (k = 0; k < NBUF; k++) begin
			buf_used[k] = 9'd0;
			buf_room[k] = 1'b0;
		end
		repeat (6) @(posedge clk);
		arst_n <= 1'b1;
		@(negedge clk);

		// first-choice slot, fallback scan, double free, unopened buffers
		push_plan(PLAN_FREE_ANY, 0, 0);
		push_plan(PLAN_ALLOC);
		push_plan(PLAN_ALLOC);
		push_plan(PLAN_ALLOC);
		push_plan(PLAN_FREE_ANY, 0, 1);
		push_plan(PLAN_ALLOC);
		push_plan(PLAN_FREE_ANY, 0, 1);
		push_plan(PLAN_FREE_ANY, 0, 1);
		push_plan(PLAN_FREE_ANY, 0, 255);
		push_plan(PLAN_FREE_ANY, 15, 255);
		push_plan(PLAN_FREE_ANY, 1, 0);
		push_plan(PLAN_FREE_ANY, 10, 170);
		push_plan(PLAN_FREE_ANY, 5, 85);
		push_plan(PLAN_FREE_ANY, 0, 0);
		push_plan(PLAN_FREE_ANY, 0, 2);
		push_plan(PLAN_FREE_ANY, 0, 0);
		push_plan(PLAN_ALLOC);
		push_plan(PLAN_ALLOC);

		// fill buffer 0 to the new size, then open and fill buffer 1
		write_slots(9'd4);
		repeat (6) push_plan(PLAN_ALLOC);

		// grow the size: buffer 1 ends up flagged with an empty bitmap
		write_slots(9'd8);
		push_plan(PLAN_FREE_ANY, 1, 0);
		push_plan(PLAN_ALLOC);
		push_plan(PLAN_ALLOC);
		plan_mix(60, 55, 35);

		write_slots(9'd256);
		plan_mix(100, 55, 35);

		write_slots(9'd511);
		plan_mix(50, 55, 35);

		write_slots(9'd37);
		plan_mix(80, 50, 40);

		// one-slot buffers: run out of buffers
		write_slots(9'd0);
		repeat (24) push_plan(PLAN_ALLOC);
		plan_mix(40, 60, 30);

		write_slots(9'd1);
		quiet = 1'b1;
		plan_mix(50, 60, 30);

		settle();
		repeat (DRAIN) @(posedge clk);
		if (faults == 0 && owed_results.size() == 0)
			$display("Regression PASS");
		else
			$display("Regression FAIL");
		$finish;
	end

endmodule

// ===== filelist.f =====
hdl/bsa_pkg.sv
hdl/bsa_bitmap_ram.sv
hdl/bsa_lsb_find.sv
hdl/bitmap_slot_allocator.sv
dv/tb.sv
